@@ hdl/iccp_pkg.sv @@
// ----------------------------------------------------------------------------
// iccp_pkg
// Shared types, constants and helpers for the profile header / tag parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iccp_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_MALF  = 2'd2,
        ST_LIMIT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_FIELD  = 2'd0,
        KIND_TAG    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    localparam logic [1:0] REG_MAX_TAG_COUNT  = 2'd0;
    localparam logic [1:0] REG_MAX_TAG_SIZE   = 2'd1;
    localparam logic [1:0] REG_MAX_TOTAL_SIZE = 2'd2;

    localparam int HDR_BYTES      = 40;
    localparam logic [31:0] MIN_PROFILE_LEN = 32'd132;
    localparam logic [31:0] SIG_ACSP        = 32'h61637370;
    localparam logic [35:0] TABLE_START     = 36'd132;
    localparam logic [3:0]  BURST_LAST      = 4'd12;
    localparam logic [3:0]  PHASE_SIZE_END  = 4'd11;
    localparam logic [3:0]  PHASE_OFF_END   = 4'd7;
    localparam int FIFO_DEPTH     = 4;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  field_offset;
        logic [2:0]  element_index;
        logic [63:0] field_value;
        logic [31:0] tag_offset;
        logic [31:0] tag_size;
        status_t     status;
        logic [31:0] entry_count;
        logic        last_result;
    } result_t;

    function automatic status_t raise_status(status_t cur, status_t s);
        status_t r;
        r = cur;
        if (s != ST_OK && cur != ST_LIMIT) begin
            if (s == ST_LIMIT)
                r = ST_LIMIT;
            else if (cur != ST_MALF) begin
                if (s == ST_MALF)
                    r = ST_MALF;
                else if (cur == ST_OK)
                    r = s;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [3:0] k);
        logic [32:0] t;
        t = {1'b0, a} + {29'b0, k};
        return t[32] ? 32'hFFFF_FFFF : t[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/iccp_byte_if.sv @@
// ----------------------------------------------------------------------------
// iccp_byte_if
// Profile byte channel: one request carries one profile byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface iccp_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] profile_length;
    logic        last_byte;

    modport source (output valid, data_byte, first_byte, profile_length, last_byte,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, profile_length, last_byte,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/iccp_result_if.sv @@
// ----------------------------------------------------------------------------
// iccp_result_if
// Result channel: one request carries one header field, tag or status.
// ----------------------------------------------------------------------------
`default_nettype none

interface iccp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [6:0]  field_offset;
    logic [2:0]  element_index;
    logic [63:0] field_value;
    logic [31:0] tag_offset;
    logic [31:0] tag_size;
    logic [1:0]  decode_status;
    logic [31:0] entry_count;
    logic        last_result;

    modport source (output valid, result_kind, field_offset, element_index, field_value,
                    tag_offset, tag_size, decode_status, entry_count, last_result,
                    input ready);
    modport sink   (input valid, result_kind, field_offset, element_index, field_value,
                    tag_offset, tag_size, decode_status, entry_count, last_result,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/icc_profile_header_tag_parser_unit.sv @@
// ----------------------------------------------------------------------------
// icc_profile_header_tag_parser_unit
// Parses an ICC profile byte stream: header fields, tag table, final status.
//
//  channel   | dir | request
//  profile   | in  | one profile byte with first/last marks and length
//  result    | out | header field, accepted tag or final status
//  write_*   | in  | register write, no wait
//
//  One byte per cycle while input is not stalled; each byte is parsed in the
//  cycle it is taken and its results go to a 4-entry result queue.
//  At byte 39 of a supported profile 13 header results follow, one a cycle
//  while the queue has room, and no byte is taken until all are queued.
//  A byte that gives a field and the status holds input until the status is queued.
//  Input stalls while the queue cannot take two results. Reset clears control.
// ----------------------------------------------------------------------------
`default_nettype none

module icc_profile_header_tag_parser_unit
    import iccp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    iccp_byte_if.sink        profile,
    iccp_result_if.source    result,
    input  wire logic        write_enable,
    input  wire logic [1:0]  reg_index,
    input  wire logic [63:0] write_data
);

    logic [31:0] max_tag_count_reg;
    logic [31:0] max_tag_size_reg;
    logic [63:0] max_total_reg;

    logic [31:0] pos_reg;
    logic [7:0]  hb_reg [HDR_BYTES];
    logic [63:0] ws_reg;
    logic [31:0] len_reg;
    logic [63:0] total_reg;
    logic [31:0] rem_reg;
    logic [63:0] ef_reg;
    status_t     status_reg;
    logic        stop_reg;
    logic [31:0] cnt_reg;
    logic [3:0]  phase_reg;

    logic        burst_reg;
    logic [3:0]  bidx_reg;
    logic        pend_reg;
    result_t     pend_data_reg;

    result_t     fifo_reg [FIFO_DEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    // per-byte parse
    logic [31:0] b_pos, b_len, b_rem, b_cnt, p, w32, declared;
    logic [63:0] b_ws, b_total, b_ef, ws_new, tag_sum;
    status_t     b_st;
    logic        b_stop;
    logic [3:0]  b_phase;
    logic [35:0] tbl_end;
    logic [32:0] end_sum;

    logic [31:0] pos_next, rem_next, cnt_next;
    logic [63:0] ws_next, total_next, ef_next;
    status_t     st_next;
    logic        stop_next;
    logic [3:0]  phase_next;
    logic        hb_shift, flush, item_res_valid;
    result_t     item_res, stat_res, burst_res, push_data;

    logic accept, pop, push, burst_push, pend_push;

    always_comb
    begin
        if (profile.first_byte)
        begin
            b_pos   = '0;
            b_ws    = '0;
            b_len   = profile.profile_length;
            b_total = '0;
            b_rem   = '0;
            b_ef    = '0;
            b_st    = ST_OK;
            b_stop  = 1'b0;
            b_cnt   = '0;
            b_phase = '0;
        end
        else
        begin
            b_pos   = pos_reg;
            b_ws    = ws_reg;
            b_len   = len_reg;
            b_total = total_reg;
            b_rem   = rem_reg;
            b_ef    = ef_reg;
            b_st    = status_reg;
            b_stop  = stop_reg;
            b_cnt   = cnt_reg;
            b_phase = phase_reg;
        end

        p        = b_pos;
        pos_next = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
        ws_new   = {b_ws[55:0], profile.data_byte};
        w32      = ws_new[31:0];
        declared = {hb_reg[1], hb_reg[2], hb_reg[3], hb_reg[4]};
        tag_sum  = b_total + {32'b0, w32};
        tbl_end  = TABLE_START + {1'b0, w32, 3'b0} + {2'b0, w32, 2'b0};
        end_sum  = {1'b0, b_ef[31:0]} + {1'b0, w32};

        ws_next    = b_ws;
        total_next = b_total;
        rem_next   = b_rem;
        ef_next    = b_ef;
        st_next    = b_st;
        stop_next  = b_stop;
        cnt_next   = b_cnt;
        phase_next = b_phase;
        hb_shift   = 1'b0;
        flush      = 1'b0;
        item_res_valid = 1'b0;
        item_res   = '0;
        item_res.kind = KIND_FIELD;

        if (!b_stop)
        begin
            ws_next = ws_new;
            if (p < 32'd40)
            begin
                hb_shift = 1'b1;
                if (p == 32'd39 && !profile.last_byte)
                begin
                    if (b_len < MIN_PROFILE_LEN ||
                        {hb_reg[37], hb_reg[38], hb_reg[39], profile.data_byte} != SIG_ACSP)
                    begin
                        st_next   = ST_UNSUP;
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        if (declared != 32'd0 && declared != b_len)
                            st_next = raise_status(st_next, ST_MALF);
                        cnt_next = sat_add(cnt_next, 4'd8);
                        flush    = 1'b1;
                    end
                end
            end
            else if (p < 32'd132)
            begin
                case (p[7:0])
                    8'd43, 8'd47, 8'd51, 8'd55, 8'd67, 8'd83:
                    begin
                        item_res_valid = 1'b1;
                        item_res.field_offset = 7'(p[7:0] - 8'd3);
                        item_res.field_value  = {32'b0, w32};
                        cnt_next = sat_add(cnt_next, 4'd1);
                    end
                    8'd63:
                    begin
                        item_res_valid = 1'b1;
                        item_res.field_offset = 7'd56;
                        item_res.field_value  = ws_new;
                        cnt_next = sat_add(cnt_next, 4'd1);
                    end
                    8'd71, 8'd75, 8'd79:
                    begin
                        item_res_valid = 1'b1;
                        item_res.field_offset  = 7'd68;
                        item_res.element_index = 3'((p[7:0] - 8'd71) >> 2);
                        item_res.field_value   = {32'b0, w32};
                        if (p[7:0] == 8'd79)
                            cnt_next = sat_add(cnt_next, 4'd1);
                    end
                    8'd91, 8'd99:
                    begin
                        item_res_valid = 1'b1;
                        item_res.field_offset  = 7'd84;
                        item_res.element_index = (p[7:0] == 8'd99) ? 3'd1 : 3'd0;
                        item_res.field_value   = ws_new;
                        if (p[7:0] == 8'd99)
                            cnt_next = sat_add(cnt_next, 4'd1);
                    end
                    8'd131:
                    begin
                        if (w32 > max_tag_count_reg)
                        begin
                            st_next   = ST_LIMIT;
                            stop_next = 1'b1;
                        end
                        else if (tbl_end > {4'b0, b_len})
                        begin
                            st_next   = ST_MALF;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            rem_next = w32;
                            if (w32 == 32'd0)
                                stop_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (b_rem == 32'd0)
                stop_next = 1'b1;
            else
            begin
                phase_next = (b_phase == PHASE_SIZE_END) ? 4'd0 : b_phase + 4'd1;
                if (b_phase == PHASE_OFF_END)
                    ef_next = ws_new;
                if (b_phase == PHASE_SIZE_END)
                begin
                    if (w32 > max_tag_size_reg)
                        st_next = raise_status(st_next, ST_LIMIT);
                    else
                    begin
                        total_next = tag_sum;
                        if (max_total_reg != 64'd0 && tag_sum > max_total_reg)
                            st_next = raise_status(st_next, ST_LIMIT);
                        else if (end_sum > {1'b0, b_len})
                            st_next = raise_status(st_next, ST_MALF);
                        else
                        begin
                            item_res_valid = 1'b1;
                            item_res.kind        = KIND_TAG;
                            item_res.field_value = {32'b0, b_ef[63:32]};
                            item_res.tag_offset  = b_ef[31:0];
                            item_res.tag_size    = w32;
                            cnt_next = sat_add(cnt_next, 4'd1);
                        end
                    end
                    rem_next = b_rem - 32'd1;
                    if (b_rem == 32'd1)
                        stop_next = 1'b1;
                end
            end
        end

        if (profile.last_byte && !stop_next)
        begin
            if (p <= 32'd39)
                st_next = ST_UNSUP;
            else
                st_next = raise_status(st_next, ST_MALF);
            stop_next = 1'b1;
        end

        stat_res = '0;
        stat_res.kind        = KIND_STATUS;
        stat_res.status      = st_next;
        stat_res.entry_count = cnt_next;
        stat_res.last_result = 1'b1;
    end

    // header burst, read from the front of the header shift line
    always_comb
    begin
        burst_res = '0;
        burst_res.kind = KIND_FIELD;
        if (bidx_reg < 4'd6)
        begin
            burst_res.field_offset = {2'b0, bidx_reg[2:0], 2'b0};
            burst_res.field_value  = {32'b0, hb_reg[0], hb_reg[1], hb_reg[2], hb_reg[3]};
        end
        else if (bidx_reg < BURST_LAST)
        begin
            burst_res.field_offset  = 7'd24;
            burst_res.element_index = 3'(bidx_reg - 4'd6);
            burst_res.field_value   = {48'b0, hb_reg[0], hb_reg[1]};
        end
        else
        begin
            burst_res.field_offset = 7'd36;
            burst_res.field_value  = {32'b0, hb_reg[0], hb_reg[1], hb_reg[2], hb_reg[3]};
        end
    end

    assign profile.ready = !burst_reg && !pend_reg && (count_reg <= 3'(FIFO_DEPTH - 2));
    assign accept     = profile.valid && profile.ready;
    assign pop        = result.valid && result.ready;
    assign burst_push = burst_reg && (count_reg < 3'(FIFO_DEPTH));
    assign pend_push  = pend_reg && (count_reg < 3'(FIFO_DEPTH));

    always_comb
    begin
        push      = 1'b0;
        push_data = stat_res;
        if (accept)
        begin
            push      = item_res_valid || profile.last_byte;
            push_data = item_res_valid ? item_res : stat_res;
        end
        else if (burst_push)
        begin
            push      = 1'b1;
            push_data = burst_res;
        end
        else if (pend_push)
        begin
            push      = 1'b1;
            push_data = pend_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tag_count_reg <= 32'hFFFF_FFFF;
            max_tag_size_reg  <= 32'hFFFF_FFFF;
            max_total_reg     <= '0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                REG_MAX_TAG_COUNT:  max_tag_count_reg <= write_data[31:0];
                REG_MAX_TAG_SIZE:   max_tag_size_reg  <= write_data[31:0];
                REG_MAX_TOTAL_SIZE: max_total_reg     <= write_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ws_reg     <= '0;
            len_reg    <= '0;
            total_reg  <= '0;
            rem_reg    <= '0;
            ef_reg     <= '0;
            status_reg <= ST_OK;
            stop_reg   <= 1'b0;
            cnt_reg    <= '0;
            phase_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            ws_reg     <= ws_next;
            len_reg    <= b_len;
            total_reg  <= total_next;
            rem_reg    <= rem_next;
            ef_reg     <= ef_next;
            status_reg <= st_next;
            stop_reg   <= stop_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= 1'b0;
            bidx_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (accept && flush)
            begin
                burst_reg <= 1'b1;
                bidx_reg  <= '0;
            end
            else if (burst_push)
            begin
                if (bidx_reg == BURST_LAST)
                    burst_reg <= 1'b0;
                bidx_reg <= bidx_reg + 4'd1;
            end
            if (accept && item_res_valid && profile.last_byte)
                pend_reg <= 1'b1;
            else if (pend_push && !burst_reg)
                pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item_res_valid && profile.last_byte)
            pend_data_reg <= stat_res;
    end

    always_ff @(posedge clk)
    begin
        if (accept && hb_shift)
        begin
            for (int i = 0; i < HDR_BYTES - 1; i++)
                hb_reg[i] <= hb_reg[i + 1];
            hb_reg[HDR_BYTES - 1] <= profile.data_byte;
        end
        else if (burst_push)
        begin
            if (bidx_reg >= 4'd6 && bidx_reg < BURST_LAST)
            begin
                for (int i = 0; i < HDR_BYTES - 2; i++)
                    hb_reg[i] <= hb_reg[i + 2];
            end
            else
            begin
                for (int i = 0; i < HDR_BYTES - 4; i++)
                    hb_reg[i] <= hb_reg[i + 4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    assign result.valid         = (count_reg != 3'd0);
    assign result.result_kind   = fifo_reg[rd_ptr_reg].kind;
    assign result.field_offset  = fifo_reg[rd_ptr_reg].field_offset;
    assign result.element_index = fifo_reg[rd_ptr_reg].element_index;
    assign result.field_value   = fifo_reg[rd_ptr_reg].field_value;
    assign result.tag_offset    = fifo_reg[rd_ptr_reg].tag_offset;
    assign result.tag_size      = fifo_reg[rd_ptr_reg].tag_size;
    assign result.decode_status = fifo_reg[rd_ptr_reg].status;
    assign result.entry_count   = fifo_reg[rd_ptr_reg].entry_count;
    assign result.last_result   = fifo_reg[rd_ptr_reg].last_result;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(FIFO_DEPTH))
        else $error("result queue overrun");

    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(burst_reg) |-> $past(accept))
        else $error("header burst without a byte");

    a_burst_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !(burst_reg && pend_reg))
        else $error("burst and pending status together");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.last_result) |-> (result.result_kind == KIND_STATUS))
        else $error("last mark on a non-status request");

endmodule

`default_nettype wire

@@ tb/icc_profile_header_tag_parser_unit_tb.sv @@
// ----------------------------------------------------------------------------
// icc_profile_header_tag_parser_unit_tb
// Streams profile images of sound and damaged shape through the parser with
// random gaps on both channels. A behavioural header/tag-table decoder in the
// bench predicts each header field, tag and status request, and every result
// is checked in order. The limit registers move between profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module icc_profile_header_tag_parser_unit_tb;
    import iccp_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic [31:0] plen;
        logic        last;
    } byte_req_t;

    logic        clk;
    logic        rst_n;
    logic        write_enable;
    logic [1:0]  reg_index;
    logic [63:0] write_data;

    iccp_byte_if   prof();
    iccp_result_if res();

    icc_profile_header_tag_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .profile      (prof),
        .result       (res),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // register copies
    logic [31:0] lim_count;
    logic [31:0] lim_size;
    logic [63:0] lim_total;

    // decoder state
    logic [31:0] pos;
    logic [7:0]  hdr [0:39];
    logic [63:0] shift_word;
    logic [31:0] prof_len;
    logic [63:0] size_sum;
    logic [31:0] tags_left;
    logic [63:0] entry_word;
    status_t     cur_status;
    logic        halted;
    logic [31:0] entries;

    byte_req_t pending_bytes[$];
    result_t   expected_results[$];

    int  errors;
    int  bytes_sent;
    int  results_seen;
    int  settings_used;
    bit  holding;
    int  send_gap;
    int  recv_gap;
    bit  steady;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic status_t escalate(status_t cur, status_t s);
        if (s == ST_OK || cur == ST_LIMIT)
            return cur;
        if (s == ST_LIMIT)
            return ST_LIMIT;
        if (cur == ST_MALF)
            return cur;
        if (s == ST_MALF)
            return ST_MALF;
        return (cur == ST_OK) ? s : cur;
    endfunction

    function automatic void bump_entries(logic [31:0] k);
        logic [32:0] t;
        t = {1'b0, entries} + {1'b0, k};
        entries = t[32] ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic void emit(kind_t k, logic [6:0] fo, logic [2:0] ei, logic [63:0] v,
                                 logic [31:0] toff, logic [31:0] tsz, status_t st,
                                 logic [31:0] cnt, logic lst);
        result_t r;
        r.kind = k;
        r.field_offset = fo;
        r.element_index = ei;
        r.field_value = v;
        r.tag_offset = toff;
        r.tag_size = tsz;
        r.status = st;
        r.entry_count = cnt;
        r.last_result = lst;
        expected_results.push_back(r);
    endfunction

    function automatic logic [31:0] hdr_word(int at);
        return {hdr[at], hdr[at+1], hdr[at+2], hdr[at+3]};
    endfunction

    function automatic void clear_parser();
        pos = 0;
        for (int i = 0; i < 40; i++)
            hdr[i] = 8'h00;
        shift_word = 0;
        prof_len = 0;
        size_sum = 0;
        tags_left = 0;
        entry_word = 0;
        cur_status = ST_OK;
        halted = 1'b0;
        entries = 0;
    endfunction

    function automatic void flush_header();
        logic [31:0] declared;
        if (prof_len < MIN_PROFILE_LEN || hdr_word(36) != SIG_ACSP) begin
            cur_status = ST_UNSUP;
            halted = 1'b1;
            return;
        end
        declared = hdr_word(0);
        if (declared != 0 && declared != prof_len)
            cur_status = escalate(cur_status, ST_MALF);
        for (int i = 0; i < 24; i += 4)
            emit(KIND_FIELD, 7'(i), 3'd0, {32'b0, hdr_word(i)}, 0, 0, ST_OK, 0, 1'b0);
        for (int i = 0; i < 6; i++)
            emit(KIND_FIELD, 7'd24, 3'(i), {48'b0, hdr[24+2*i], hdr[25+2*i]}, 0, 0,
                 ST_OK, 0, 1'b0);
        emit(KIND_FIELD, 7'd36, 3'd0, {32'b0, hdr_word(36)}, 0, 0, ST_OK, 0, 1'b0);
        bump_entries(8);
    endfunction

    function automatic void decode_byte(byte_req_t b);
        logic [31:0] p;
        logic [31:0] w32;
        logic [31:0] ph;
        logic [31:0] tsig;
        logic [31:0] toff;
        if (b.first) begin
            clear_parser();
            prof_len = b.plen;
        end
        p = pos;
        if (pos != 32'hFFFF_FFFF)
            pos = pos + 1;
        if (!halted) begin
            shift_word = {shift_word[55:0], b.data};
            w32 = shift_word[31:0];
            if (p < 40) begin
                hdr[p] = b.data;
                if (p == 39 && !b.last)
                    flush_header();
            end
            else if (p < 132) begin
                case (p)
                    43, 47, 51, 55, 67, 83:
                    begin
                        emit(KIND_FIELD, 7'(p - 3), 3'd0, {32'b0, w32}, 0, 0, ST_OK, 0, 1'b0);
                        bump_entries(1);
                    end
                    63:
                    begin
                        emit(KIND_FIELD, 7'd56, 3'd0, shift_word, 0, 0, ST_OK, 0, 1'b0);
                        bump_entries(1);
                    end
                    71, 75, 79:
                    begin
                        emit(KIND_FIELD, 7'd68, 3'((p - 71) / 4), {32'b0, w32}, 0, 0,
                             ST_OK, 0, 1'b0);
                        if (p == 79)
                            bump_entries(1);
                    end
                    91, 99:
                    begin
                        emit(KIND_FIELD, 7'd84, 3'((p - 91) / 8), shift_word, 0, 0,
                             ST_OK, 0, 1'b0);
                        if (p == 99)
                            bump_entries(1);
                    end
                    131:
                    begin
                        if (w32 > lim_count) begin
                            cur_status = ST_LIMIT;
                            halted = 1'b1;
                        end
                        else if (64'd132 + {32'b0, w32} * 64'd12 > {32'b0, prof_len}) begin
                            cur_status = ST_MALF;
                            halted = 1'b1;
                        end
                        else begin
                            tags_left = w32;
                            if (w32 == 0)
                                halted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            else if (tags_left == 0)
                halted = 1'b1;
            else begin
                ph = (p - 132) % 12;
                if (ph == PHASE_OFF_END)
                    entry_word = shift_word;
                if (ph == PHASE_SIZE_END) begin
                    tsig = entry_word[63:32];
                    toff = entry_word[31:0];
                    if (w32 > lim_size)
                        cur_status = escalate(cur_status, ST_LIMIT);
                    else begin
                        size_sum = size_sum + {32'b0, w32};
                        if (lim_total != 0 && size_sum > lim_total)
                            cur_status = escalate(cur_status, ST_LIMIT);
                        else if ({32'b0, toff} + {32'b0, w32} > {32'b0, prof_len})
                            cur_status = escalate(cur_status, ST_MALF);
                        else begin
                            emit(KIND_TAG, 0, 0, {32'b0, tsig}, toff, w32, ST_OK, 0, 1'b0);
                            bump_entries(1);
                        end
                    end
                    tags_left = tags_left - 1;
                    if (tags_left == 0)
                        halted = 1'b1;
                end
            end
        end
        if (b.last) begin
            if (!halted) begin
                if (p <= 39)
                    cur_status = ST_UNSUP;
                else
                    cur_status = escalate(cur_status, ST_MALF);
                halted = 1'b1;
            end
            emit(KIND_STATUS, 0, 0, 0, 0, 0, cur_status, entries, 1'b1);
        end
    endfunction

    // profile byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prof.valid <= 1'b0;
            prof.data_byte <= 8'h00;
            prof.first_byte <= 1'b0;
            prof.profile_length <= 32'h0;
            prof.last_byte <= 1'b0;
            holding = 1'b0;
            send_gap = 0;
        end
        else begin
            byte_req_t b;
            if (prof.valid && prof.ready) begin
                b.data = prof.data_byte;
                b.first = prof.first_byte;
                b.plen = prof.profile_length;
                b.last = prof.last_byte;
                decode_byte(b);
                bytes_sent++;
                holding = 1'b0;
                send_gap = steady ? 0 : $urandom_range(0, 5);
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    prof.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0) begin
                    b = pending_bytes.pop_front();
                    prof.valid <= 1'b1;
                    prof.data_byte <= b.data;
                    prof.first_byte <= b.first;
                    prof.profile_length <= b.plen;
                    prof.last_byte <= b.last;
                    holding = 1'b1;
                end
                else
                    prof.valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res.ready <= 1'b0;
            recv_gap = 0;
        end
        else begin
            result_t e;
            if (res.valid && res.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result request, kind %0d", res.result_kind);
                    errors++;
                end
                else begin
                    e = expected_results.pop_front();
                    check_field("result_kind", e.kind, res.result_kind);
                    check_field("field_offset", e.field_offset, res.field_offset);
                    check_field("element_index", e.element_index, res.element_index);
                    check_field("field_value", e.field_value, res.field_value);
                    check_field("tag_offset", e.tag_offset, res.tag_offset);
                    check_field("tag_size", e.tag_size, res.tag_size);
                    check_field("decode_status", e.status, res.decode_status);
                    check_field("entry_count", e.entry_count, res.entry_count);
                    check_field("last_result", e.last_result, res.last_result);
                end
                recv_gap = steady ? 0 : $urandom_range(0, 5);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    function automatic void put32(ref logic [7:0] img[$], input int at, input logic [31:0] v);
        img[at] = v[31:24];
        img[at+1] = v[23:16];
        img[at+2] = v[15:8];
        img[at+3] = v[7:0];
    endfunction

    function automatic void queue_bytes(ref logic [7:0] img[$], input int stop,
                                        input logic [31:0] plen, input bit with_first);
        byte_req_t b;
        for (int i = 0; i < stop; i++) begin
            b.data = img[i];
            b.first = with_first && (i == 0);
            b.plen = plen;
            b.last = (i == stop - 1);
            pending_bytes.push_back(b);
        end
    endfunction

    // sound or damaged profiles; damaged ones bend length, signature, count or tags, or end early
    function automatic void queue_profile(int ntags, bit sound);
        logic [7:0]  img[$];
        int          nb;
        int          stop;
        int          base;
        logic [31:0] plen;
        logic [31:0] sz;
        logic [31:0] off;
        nb = 132 + 12 * ntags + $urandom_range(0, 6);
        plen = nb;
        if (!sound && $urandom_range(0, 3) == 0)
            plen = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 131);
        for (int i = 0; i < nb; i++)
            img.push_back(8'($urandom));
        case ($urandom_range(0, 3))
            0: put32(img, 0, 0);
            1: put32(img, 0, sound ? plen : $urandom);
            default: put32(img, 0, plen);
        endcase
        if (sound || $urandom_range(0, 3) != 0)
            put32(img, 36, SIG_ACSP);
        if (!sound && $urandom_range(0, 3) == 0)
            put32(img, 128, $urandom_range(0, 1) ? $urandom : ntags + $urandom_range(1, 3));
        else
            put32(img, 128, ntags);
        for (int t = 0; t < ntags; t++) begin
            base = 132 + 12 * t;
            sz = (!sound && $urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
            if (sz < nb)
                off = $urandom_range(0, nb - sz);
            else
                off = $urandom;
            if (!sound && $urandom_range(0, 4) == 0)
                off = plen - sz + 1;
            put32(img, base, $urandom);
            put32(img, base + 4, off);
            put32(img, base + 8, sz);
        end
        stop = nb;
        if (!sound && $urandom_range(0, 2) == 0)
            stop = $urandom_range(1, nb);
        queue_bytes(img, stop, plen, 1'b1);
    endfunction

    function automatic void queue_noise();
        logic [7:0] img[$];
        int         nb;
        nb = $urandom_range(1, 45);
        for (int i = 0; i < nb; i++)
            img.push_back(8'($urandom));
        queue_bytes(img, nb, $urandom, $urandom_range(0, 3) != 0);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] v);
        @(posedge clk);
        write_enable <= 1'b1;
        reg_index <= idx;
        write_data <= v;
        case (idx)
            REG_MAX_TAG_COUNT:  lim_count = v[31:0];
            REG_MAX_TAG_SIZE:   lim_size = v[31:0];
            REG_MAX_TOTAL_SIZE: lim_total = v;
            default: ;
        endcase
        @(posedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_bytes.size() > 0 || holding || expected_results.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_limit(int sel, logic [63:0] top, logic [63:0] mid);
        case (sel)
            0: return 0;
            1: return top;
            2: return mid;
            default: return {$urandom, $urandom} & top;
        endcase
    endfunction

    initial begin
        byte_req_t b;
        clk = 1'b0;
        errors = 0;
        bytes_sent = 0;
        results_seen = 0;
        settings_used = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        write_enable = 1'b0;
        reg_index = REG_MAX_TAG_COUNT;
        write_data = 64'h0;
        lim_count = 32'hFFFF_FFFF;
        lim_size = 32'hFFFF_FFFF;
        lim_total = 64'h0;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // no first byte after reset, a repeated status, single-byte profile
        for (int i = 0; i < 3; i++) begin
            b.data = (i == 1) ? 8'hFF : 8'h00;
            b.first = 1'b0;
            b.plen = 32'h0;
            b.last = (i == 2);
            pending_bytes.push_back(b);
        end
        b.data = 8'h5A;
        b.last = 1'b1;
        pending_bytes.push_back(b);
        b.data = 8'hFF;
        b.first = 1'b1;
        b.plen = 32'hFFFF_FFFF;
        pending_bytes.push_back(b);
        b.first = 1'b0;
        b.plen = 32'h0;
        pending_bytes.push_back(b);
        drain();

        while (bytes_sent < 450) begin
            steady = ($urandom_range(0, 4) == 0);
            write_reg(REG_MAX_TAG_COUNT, pick_limit($urandom_range(0, 4), 64'hFFFF_FFFF, 2));
            write_reg(REG_MAX_TAG_SIZE, pick_limit($urandom_range(0, 4), 64'hFFFF_FFFF, 30));
            write_reg(REG_MAX_TOTAL_SIZE, pick_limit($urandom_range(0, 4), {64{1'b1}}, 50));
            settings_used++;
            queue_profile($urandom_range(0, 3), $urandom_range(0, 1) == 0);
            if ($urandom_range(0, 1))
                queue_noise();
            drain();
        end

        $display("%0d profile bytes sent and %0d result requests checked", bytes_sent,
                 results_seen);
        $display("over %0d limit settings, sound and damaged profiles", settings_used);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
